// ===== design/qpht_pkg.sv =====
// Package of the quadratic-probe hash table: sizes, command and status codes,
// request, result and queue entry types.
// Depends on nothing; every other design file imports it.
package qpht_pkg;

  // Table geometry.
  localparam int unsigned TABLE_SIZE = 71;
  localparam int unsigned KEY_BYTES  = 8;
  localparam logic [7:0]  SKIP_BYTE  = 8'd13;

  // Field widths fixed by the interface.
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned PAY_W      = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_IDX_W = 7;

  // Internal widths derived from the table geometry.
  localparam int unsigned SLOT_W  = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W   = $clog2(TABLE_SIZE + 1);
  localparam int unsigned SUM_W   = $clog2(KEY_BYTES * 255 + 1);

  // Home slot is sum mod TABLE_SIZE, done with a reciprocal multiply.
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP       = (2 ** RECIP_SHIFT) / TABLE_SIZE;
  localparam int unsigned PROD_W      = SUM_W + RECIP_SHIFT;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key_bytes;
    logic [PAY_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [PAY_W-1:0]      payload_out;
  } rsp_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [KEY_W-1:0]  key_bytes;
    logic [PAY_W-1:0]  payload;
    logic [SLOT_W-1:0] home;
  } cmd_entry_t;

endpackage

// ===== design/quadratic_probe_hash_table_unit.sv =====
// Top level of the quadratic-probe hash table: front end, command queue and
// back end. Depends on qpht_pkg, qpht_front, qpht_cmd_queue and qpht_back.
//
//   Channel   Direction  Handshake         Payload
//   request   in         push / full       req_i  (command, key_bytes, payload)
//   result    out        empty / pop       rsp_o  (status, slot_index, payload_out)
//
// A request passes the front end (byte sum, reciprocal multiply, remainder) and
// then waits in a two-entry command queue. The back end picks it up, then takes
// one step per probed slot and one more per key read. Reset clears the slot
// flags and the entry count but not the key and payload memories. The front end
// keeps accepting while the back end probes or a result waits, until its stages
// and the queue fill.
module quadratic_probe_hash_table_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  qpht_pkg::req_t  req_i,
  output logic            empty,
  input  logic            pop,
  output qpht_pkg::rsp_t  rsp_o
);
  import qpht_pkg::*;

  // Front end to queue.
  logic       q_push;
  logic       q_full;
  cmd_entry_t q_entry_in;

  // Queue to back end.
  logic       q_pop;
  logic       q_empty;
  cmd_entry_t q_entry_out;

  // Number of occupied slots, watched by the checks below.
  logic [CNT_W-1:0] entry_count;

  qpht_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .req_i     (req_i),
    .q_push_o  (q_push),
    .q_full_i  (q_full),
    .q_entry_o (q_entry_in)
  );

  qpht_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (q_entry_out)
  );

  // The back end answers every request with exactly one result.
  qpht_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_entry_i     (q_entry_out),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .rsp_o         (rsp_o),
    .entry_count_o (entry_count)
  );

  // The table never holds more than one entry short of its size.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count <= CNT_W'(TABLE_SIZE - 1))
    else $error("entry count exceeds table limit");

  // A failed request reports neither a slot nor a payload.
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.status != ST_DONE) |->
      (rsp_o.slot_index == '0 && rsp_o.payload_out == '0))
    else $error("failed result carries slot or payload");

  // A reported slot lies inside the table.
  a_slot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> rsp_o.slot_index < SLOT_IDX_W'(TABLE_SIZE))
    else $error("result slot outside table");

  // The back end only takes a command the queue actually holds.
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("command taken from empty queue");

endmodule

// ===== design/qpht_front.sv =====
// Front end of the hash table: accepts requests and computes the home slot.
// Depends on qpht_pkg.
module qpht_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  qpht_pkg::req_t      req_i,
  output logic                q_push_o,
  input  logic                q_full_i,
  output qpht_pkg::cmd_entry_t q_entry_o
);
  import qpht_pkg::*;

  logic              s1_valid_q, s1_valid_d;
  req_t              s1_req_q;
  logic [SUM_W-1:0]  s1_sum_q;
  logic [SUM_W-1:0]  byte_sum;

  logic              s2_valid_q, s2_valid_d;
  req_t              s2_req_q;
  logic [SUM_W-1:0]  s2_sum_q;
  logic [SUM_W-1:0]  s2_quo_q;

  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  rem_raw;
  logic [SUM_W-1:0]  rem;

  logic s1_ready, s2_ready, in_acc, s1_adv;

  // Key byte sum, bytes equal to the skip value left out.
  always_comb begin
    byte_sum = '0;
    for (int i = 0; i < int'(KEY_BYTES); i++) begin
      if (req_i.key_bytes[8*i +: 8] != SKIP_BYTE) begin
        byte_sum = byte_sum + SUM_W'(req_i.key_bytes[8*i +: 8]);
      end
    end
  end

  assign prod = PROD_W'(s1_sum_q) * PROD_W'(RECIP);

  // Quotient estimate is exact or one low, so one correction suffices.
  always_comb begin
    rem_raw = s2_sum_q - SUM_W'(s2_quo_q * SUM_W'(TABLE_SIZE));
    rem     = rem_raw;
    if (rem_raw >= SUM_W'(TABLE_SIZE)) begin
      rem = rem_raw - SUM_W'(TABLE_SIZE);
    end
  end

  assign s2_ready = !s2_valid_q || !q_full_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign full     = !s1_ready;
  assign in_acc   = push && s1_ready;
  assign s1_adv   = s1_valid_q && s2_ready;

  assign q_push_o  = s2_valid_q && !q_full_i;
  assign q_entry_o = '{command:   s2_req_q.command,
                       key_bytes: s2_req_q.key_bytes,
                       payload:   s2_req_q.payload,
                       home:      SLOT_W'(rem)};

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_ready) begin
      s1_valid_d = push;
    end
    s2_valid_d = s2_valid_q;
    if (s2_ready) begin
      s2_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q <= req_i;
      s1_sum_q <= byte_sum;
    end
    if (s1_adv) begin
      s2_req_q <= s1_req_q;
      s2_sum_q <= s1_sum_q;
      s2_quo_q <= prod[RECIP_SHIFT +: SUM_W];
    end
  end

endmodule

// ===== design/qpht_cmd_queue.sv =====
// Two-entry queue of classified commands between front and back end.
// Depends on qpht_pkg.
module qpht_cmd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  qpht_pkg::cmd_entry_t entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output qpht_pkg::cmd_entry_t entry_o
);
  import qpht_pkg::*;

  cmd_entry_t  slots_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;
  logic        do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = slots_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== design/qpht_back.sv =====
// Back end of the hash table: probe sequencer, slot memories, slot flags
// and the result register. Depends on qpht_pkg.
module qpht_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  qpht_pkg::cmd_entry_t q_entry_i,
  output logic                 q_pop_o,
  output logic                 empty,
  input  logic                 pop,
  output qpht_pkg::rsp_t       rsp_o,
  output logic [qpht_pkg::CNT_W-1:0] entry_count_o
);
  import qpht_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [PAY_W-1:0]      pay_q, pay_d;
  logic [SLOT_W-1:0]     pos_q, pos_d;
  logic [SLOT_W-1:0]     step_q, step_d;
  logic [SLOT_W-1:0]     inc_q, inc_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [TABLE_SIZE-1:0] occ_q, occ_d;
  logic [TABLE_SIZE-1:0] tomb_q, tomb_d;
  logic                  res_valid_q, res_valid_d;
  rsp_t                  res_q, res_d;

  logic [KEY_W-1:0] key_mem [TABLE_SIZE];
  logic [PAY_W-1:0] pay_mem [TABLE_SIZE];
  logic [KEY_W-1:0] key_rd_q;
  logic [PAY_W-1:0] pay_rd_q;
  logic             wr_en, rd_en;

  logic              res_free, last_step;
  logic [SLOT_W:0]   pos_sum, inc_sum;
  logic [SLOT_W-1:0] pos_next, inc_next;
  logic [STATUS_W-1:0] miss_status;

  assign res_free    = !res_valid_q || pop;
  assign last_step   = (step_q == SLOT_W'(TABLE_SIZE - 1));
  assign miss_status = (cmd_q == CMD_INSERT) ? ST_FULL : ST_MISSING;

  // Next probe position and next increment (two more than the last), both kept below TABLE_SIZE.
  always_comb begin
    pos_sum  = {1'b0, pos_q} + {1'b0, inc_q};
    pos_next = pos_sum[SLOT_W-1:0];
    if (pos_sum >= (SLOT_W+1)'(TABLE_SIZE)) begin
      pos_next = SLOT_W'(pos_sum - (SLOT_W+1)'(TABLE_SIZE));
    end
    inc_sum  = {1'b0, inc_q} + (SLOT_W+1)'(2);
    inc_next = inc_sum[SLOT_W-1:0];
    if (inc_sum >= (SLOT_W+1)'(TABLE_SIZE)) begin
      inc_next = SLOT_W'(inc_sum - (SLOT_W+1)'(TABLE_SIZE));
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    pay_d       = pay_q;
    pos_d       = pos_q;
    step_d      = step_q;
    inc_d       = inc_q;
    count_d     = count_q;
    occ_d       = occ_q;
    tomb_d      = tomb_q;
    res_valid_d = res_valid_q && !pop;
    res_d       = res_q;
    q_pop_o     = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i && res_free) begin
          q_pop_o = 1'b1;
          cmd_d   = q_entry_i.command;
          key_d   = q_entry_i.key_bytes;
          pay_d   = q_entry_i.payload;
          pos_d   = q_entry_i.home;
          step_d  = '0;
          inc_d   = SLOT_W'(1);
          if (q_entry_i.command == CMD_INSERT
              && count_q >= CNT_W'(TABLE_SIZE - 1)) begin
            res_valid_d = 1'b1;
            res_d       = '{ST_FULL, '0, '0};
          end else if (q_entry_i.command != CMD_INSERT
                       && q_entry_i.command != CMD_DELETE
                       && q_entry_i.command != CMD_FIND) begin
            res_valid_d = 1'b1;
            res_d       = '{ST_MISSING, '0, '0};
          end else begin
            state_d = S_PROBE;
          end
        end
      end

      S_PROBE: begin
        if (cmd_q == CMD_INSERT && !occ_q[pos_q]) begin
          wr_en         = 1'b1;
          occ_d[pos_q]  = 1'b1;
          tomb_d[pos_q] = 1'b0;
          count_d       = count_q + CNT_W'(1);
          res_valid_d   = 1'b1;
          res_d         = '{ST_DONE, SLOT_IDX_W'(pos_q), '0};
          state_d       = S_IDLE;
        end else if (cmd_q != CMD_INSERT && !occ_q[pos_q] && !tomb_q[pos_q]) begin
          res_valid_d = 1'b1;
          res_d       = '{ST_MISSING, '0, '0};
          state_d     = S_IDLE;
        end else if (cmd_q != CMD_INSERT && occ_q[pos_q]) begin
          rd_en   = 1'b1;
          state_d = S_CMP;
        end else if (last_step) begin
          res_valid_d = 1'b1;
          res_d       = '{miss_status, '0, '0};
          state_d     = S_IDLE;
        end else begin
          pos_d  = pos_next;
          inc_d  = inc_next;
          step_d = step_q + SLOT_W'(1);
        end
      end

      S_CMP: begin
        if (key_rd_q == key_q) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (cmd_q == CMD_FIND) begin
            res_d = '{ST_DONE, SLOT_IDX_W'(pos_q), pay_rd_q};
          end else begin
            res_d         = '{ST_DONE, SLOT_IDX_W'(pos_q), '0};
            occ_d[pos_q]  = 1'b0;
            tomb_d[pos_q] = 1'b1;
            if (count_q != '0) begin
              count_d = count_q - CNT_W'(1);
            end
          end
        end else if (last_step) begin
          res_valid_d = 1'b1;
          res_d       = '{ST_MISSING, '0, '0};
          state_d     = S_IDLE;
        end else begin
          pos_d   = pos_next;
          inc_d   = inc_next;
          step_d  = step_q + SLOT_W'(1);
          state_d = S_PROBE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign empty         = !res_valid_q;
  assign rsp_o         = res_q;
  assign entry_count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      occ_q       <= '0;
      tomb_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      occ_q       <= occ_d;
      tomb_q      <= tomb_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    pay_q  <= pay_d;
    pos_q  <= pos_d;
    step_q <= step_d;
    inc_q  <= inc_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[pos_q] <= key_q;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[pos_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pay_mem[pos_q] <= pay_q;
    end
    if (rd_en) begin
      pay_rd_q <= pay_mem[pos_q];
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for quadratic_probe_hash_table_unit: insert, delete and find requests
// against a cycle-free predictor of the 71-slot quadratic-probe table.
// Depends on qpht_pkg and the RTL of quadratic_probe_hash_table_unit only.
module testbench;
  import qpht_pkg::*;

  // Clock period is 12 ns, so the clock flips every 6 ns.
  localparam int CLK_HALF = 6;
  // Generous stop for the whole run. It allows for every request probing the
  // full table, plus stalls and the long hold-off.
  localparam int CYCLE_LIMIT = 600000;
  // Cycles to keep watching the result side once nothing is expected any more.
  // This covers the front-end pipeline plus two worst-case probe loops.
  localparam int TAIL_CYCLES = 400;
  // The command field has one unused code, which the block reports as not found.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  req_t request_data = '0;
  logic empty;
  logic pop = 1'b0;
  rsp_t rsp;

  quadratic_probe_hash_table_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .req_i  (request_data),
    .empty  (empty),
    .pop    (pop),
    .rsp_o  (rsp)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Predicted contents of the table. Keys and payloads are only read for
  // occupied slots, just like the block's own memories.
  logic [KEY_W-1:0] tbl_key [TABLE_SIZE];
  logic [PAY_W-1:0] tbl_payload [TABLE_SIZE];
  logic             tbl_live [TABLE_SIZE];
  logic             tbl_tomb [TABLE_SIZE];
  int unsigned      tbl_count = 0;

  // Results the block still owes, oldest first.
  rsp_t expected_results [$];
  rsp_t oldest_expected;

  // Idling knobs, in percent, and the long receiver hold-off. The tests ask
  // for a hold-off by setting its length and bumping the request count; the
  // receiver process alone counts the cycles down.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_len = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // Bookkeeping for the final report and the summary.
  int mismatch_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int done_seen = 0;
  int full_seen = 0;
  int missing_seen = 0;
  int full_by_count = 0;
  int full_by_probes = 0;
  int input_stall_cycles = 0;
  int cycle_count = 0;

  initial begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      tbl_live[i] = 1'b0;
      tbl_tomb[i] = 1'b0;
    end
  end

  function automatic logic chance(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // Home slot: sum of the key bytes, skipping the value 13, modulo the table size.
  function automatic int unsigned home_of_key(logic [KEY_W-1:0] key);
    int unsigned sum;
    int i;
    sum = 0;
    for (i = 0; i < KEY_BYTES; i++) begin
      if (key[8*i +: 8] != SKIP_BYTE) sum += key[8*i +: 8];
    end
    return sum % TABLE_SIZE;
  endfunction

  // Probe sequence of delete and find. It stops at a never-used slot, or
  // after one probe per slot, and returns -1 when the key is not held.
  function automatic int find_slot(logic [KEY_W-1:0] key);
    int unsigned pos;
    int unsigned t;
    int hit;
    logic searching;
    hit = -1;
    searching = 1'b1;
    pos = home_of_key(key);
    for (t = 0; t < TABLE_SIZE && searching; t++) begin
      if (tbl_live[pos] && tbl_key[pos] == key) begin
        hit = int'(pos);
        searching = 1'b0;
      end else if (!tbl_live[pos] && !tbl_tomb[pos]) begin
        searching = 1'b0;
      end else begin
        pos = (pos + 2 * t + 1) % TABLE_SIZE;
      end
    end
    return hit;
  endfunction

  // Applies one accepted request to the predicted table and returns the
  // result the block must give for it.
  function automatic rsp_t table_apply(req_t r);
    rsp_t res;
    int unsigned pos;
    int unsigned t;
    int hit;
    logic placed;
    res = '0;
    res.status = ST_MISSING;
    case (r.command)
      CMD_INSERT: begin
        res.status = ST_FULL;
        if (tbl_count < TABLE_SIZE - 1) begin
          pos = home_of_key(r.key_bytes);
          placed = 1'b0;
          for (t = 0; t < TABLE_SIZE && !placed; t++) begin
            if (!tbl_live[pos]) begin
              tbl_key[pos] = r.key_bytes;
              tbl_payload[pos] = r.payload;
              tbl_live[pos] = 1'b1;
              tbl_tomb[pos] = 1'b0;
              tbl_count++;
              res.status = ST_DONE;
              res.slot_index = SLOT_IDX_W'(pos);
              placed = 1'b1;
            end else begin
              pos = (pos + 2 * t + 1) % TABLE_SIZE;
            end
          end
          if (!placed) full_by_probes++;
        end else begin
          full_by_count++;
        end
      end
      CMD_DELETE, CMD_FIND: begin
        hit = find_slot(r.key_bytes);
        if (hit >= 0) begin
          res.status = ST_DONE;
          res.slot_index = SLOT_IDX_W'(hit);
          if (r.command == CMD_FIND) begin
            res.payload_out = tbl_payload[hit];
          end else begin
            tbl_live[hit] = 1'b0;
            tbl_tomb[hit] = 1'b1;
            if (tbl_count > 0) tbl_count--;
          end
        end
      end
      default: begin
        // The unused command code leaves the table alone and reports not found.
      end
    endcase
    return res;
  endfunction

  // Keys of several shapes: fully random, short keys with zero upper bytes,
  // keys full of skipped bytes, and lowercase text.
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    int unsigned len;
    int i;
    k = {$urandom, $urandom};
    len = $urandom_range(1, KEY_BYTES);
    case ($urandom_range(3))
      0: begin
      end
      1: k = k & ((64'd1 << (8 * len)) - 64'd1);
      2: begin
        for (i = 0; i < KEY_BYTES; i++) begin
          if (chance(40)) k[8*i +: 8] = SKIP_BYTE;
        end
      end
      default: begin
        k = '0;
        for (i = 0; i < len; i++) k[8*i +: 8] = 8'(97 + $urandom_range(25));
      end
    endcase
    return k;
  endfunction

  // A random key whose home slot is the given one. Only the low byte is
  // adjusted, and it never takes the skipped value.
  function automatic logic [KEY_W-1:0] key_with_home(int unsigned target);
    logic [KEY_W-1:0] k;
    int unsigned b;
    k = random_key();
    k[7:0] = 8'd0;
    b = (target + TABLE_SIZE - home_of_key(k)) % TABLE_SIZE;
    if (b == SKIP_BYTE) b += TABLE_SIZE;
    k[7:0] = 8'(b);
    return k;
  endfunction

  // A key that the table holds right now, or a fresh one if it holds none.
  function automatic logic [KEY_W-1:0] pick_live_key();
    int unsigned live_slots [$];
    int i;
    for (i = 0; i < TABLE_SIZE; i++) begin
      if (tbl_live[i]) live_slots.push_back(i);
    end
    if (live_slots.size() == 0) return random_key();
    return tbl_key[live_slots[$urandom_range(live_slots.size() - 1)]];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Offers one request and returns at the rising edge that accepts it. Push is
  // left high so that a following request goes out back to back; whoever
  // stops sending calls stop_requests.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [PAY_W-1:0] data);
    req_t r;
    r.command = cmd;
    r.key_bytes = key;
    r.payload = data;
    @(negedge clk_i);
    while (chance(send_idle_pct)) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    request_data <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    expected_results.push_back(table_apply(r));
    sent_count++;
  endtask

  task automatic stop_requests();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  // The sender pauses until every expected result has been popped.
  task automatic drain_results();
    stop_requests();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic delete_every_entry();
    while (tbl_count != 0) send_request(CMD_DELETE, pick_live_key(), $urandom);
  endtask

  // Hand-picked requests: empty-table misses, extreme keys and payloads,
  // collisions on one home slot, duplicate keys, probing past a tombstone,
  // reuse of a tombstone, and the unused command code.
  task automatic test_directed();
    send_request(CMD_FIND, 64'd0, 32'd0);
    send_request(CMD_DELETE, '1, 32'd0);
    send_request(CMD_INSERT, 64'd0, 32'd0);
    send_request(CMD_INSERT, '1, '1);
    send_request(CMD_INSERT, 64'h0D0D_0D0D_0D0D_0D0D, 32'hA5A5_A5A5);
    send_request(CMD_INSERT, 64'h0000_0000_0000_000D, 32'h5A5A_5A5A);
    send_request(CMD_FIND, '1, 32'd0);
    send_request(CMD_FIND, 64'h0D0D_0D0D_0D0D_0D0D, 32'd0);
    // Same key again: the table does not check for duplicates.
    send_request(CMD_INSERT, 64'd0, 32'h1234_5678);
    send_request(CMD_DELETE, 64'd0, 32'd0);
    // Both finds must walk past the tombstone just left at the home slot.
    send_request(CMD_FIND, 64'h0D0D_0D0D_0D0D_0D0D, 32'd0);
    send_request(CMD_FIND, 64'd0, 32'd0);
    send_request(CMD_INSERT, 64'h0000_0000_0000_0D00, 32'h8000_0000);
    // Same home as the cluster above but never stored: stops at a never-used slot.
    send_request(CMD_DELETE, 64'h0000_0000_0000_0D0D, 32'd0);
    send_request(CMD_UNUSED, '1, '1);
    send_request(CMD_FIND, '1, 32'hFFFF_0000);
    send_request(CMD_DELETE, '1, 32'd0);
    send_request(CMD_DELETE, '1, 32'd0);
    send_request(CMD_FIND, 64'h8000_0000_0000_0000, 32'd0);
    send_request(CMD_INSERT, 64'hFEDC_BA98_7654_3210, 32'h8000_0001);
    drain_results();
  endtask

  // Mostly requests on keys the table holds, with duplicates, misses and the
  // unused command mixed in, under one setting of the idling knobs.
  task automatic test_random_mix(input int n, input int unsigned send_pct,
                                 input int unsigned recv_pct);
    int i;
    int unsigned roll;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 28) send_request(CMD_INSERT, random_key(), $urandom);
      else if (roll < 35) send_request(CMD_INSERT, pick_live_key(), $urandom);
      else if (roll < 60) send_request(CMD_DELETE, pick_live_key(), $urandom);
      else if (roll < 80) send_request(CMD_FIND, pick_live_key(), $urandom);
      else if (roll < 88) send_request(CMD_FIND, random_key(), $urandom);
      else if (roll < 95) send_request(CMD_DELETE, random_key(), $urandom);
      else send_request(CMD_UNUSED, random_key(), $urandom);
    end
    drain_results();
  endtask

  // Offers up to 150 inserts to fill the table to its limit of TABLE_SIZE - 1
  // entries, where some inserts also fail because their probe sequence is all
  // taken, then asks for more, searches at full load, and empties the table again.
  task automatic test_fill_table();
    int attempts;
    int i;
    send_idle_pct = 17;
    recv_stall_pct = 17;
    attempts = 0;
    while (tbl_count < TABLE_SIZE - 1 && attempts < 150) begin
      send_request(CMD_INSERT, random_key(), $urandom);
      attempts++;
    end
    for (i = 0; i < 4; i++) send_request(CMD_INSERT, random_key(), $urandom);
    for (i = 0; i < 20; i++) send_request(CMD_FIND, pick_live_key(), $urandom);
    for (i = 0; i < 6; i++) send_request(CMD_FIND, random_key(), $urandom);
    for (i = 0; i < 4; i++) send_request(CMD_DELETE, random_key(), $urandom);
    delete_every_entry();
    drain_results();
  endtask

  // Piles keys onto one home slot. Quadratic probing reaches only about half
  // of the slots, so inserts run out of probes long before the table is full,
  // and searches for absent keys end only after the probe limit.
  task automatic test_one_home();
    int unsigned target;
    int i;
    send_idle_pct = 0;
    recv_stall_pct = 48;
    target = $urandom_range(TABLE_SIZE - 1);
    for (i = 0; i < 40; i++) send_request(CMD_INSERT, key_with_home(target), $urandom);
    for (i = 0; i < 4; i++) send_request(CMD_FIND, key_with_home(target), $urandom);
    for (i = 0; i < 8; i++) send_request(CMD_FIND, pick_live_key(), $urandom);
    for (i = 0; i < 10; i++) send_request(CMD_DELETE, pick_live_key(), $urandom);
    // Absent keys now have to walk over tombstones as well as live slots.
    for (i = 0; i < 4; i++) send_request(CMD_DELETE, key_with_home(target), $urandom);
    for (i = 0; i < 6; i++) send_request(CMD_INSERT, key_with_home(target), $urandom);
    delete_every_entry();
    drain_results();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering requests, so the block fills up and raises full.
  task automatic test_result_backpressure();
    int i;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 300;
    hold_requests++;
    for (i = 0; i < 40; i++) begin
      if (chance(60)) send_request(CMD_INSERT, random_key(), $urandom);
      else send_request(CMD_FIND, pick_live_key(), $urandom);
    end
    drain_results();
  endtask

  // Receiver side: pop is driven at the falling edge, low during a hold-off
  // and at random according to the current stall setting otherwise.
  always @(negedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = hold_len;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= !chance(recv_stall_pct);
    end
  end

  // Every popped result is checked field by field against the oldest
  // expectation. Outputs are sampled at the rising edge, before the block
  // updates them.
  always @(posedge clk_i) begin
    if (rst_ni && push && full) input_stall_cycles++;
    if (rst_ni && pop && !empty) begin
      checked_count++;
      case (rsp.status)
        ST_DONE: done_seen++;
        ST_FULL: full_seen++;
        default: missing_seen++;
      endcase
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", checked_count));
      end else begin
        oldest_expected = expected_results.pop_front();
        if (rsp.status !== oldest_expected.status)
          report_mismatch($sformatf("result %0d: status %0d, expected %0d", checked_count,
                                    rsp.status, oldest_expected.status));
        if (rsp.slot_index !== oldest_expected.slot_index)
          report_mismatch($sformatf("result %0d: slot_index %0d, expected %0d", checked_count,
                                    rsp.slot_index, oldest_expected.slot_index));
        if (rsp.payload_out !== oldest_expected.payload_out)
          report_mismatch($sformatf("result %0d: payload_out %h, expected %h", checked_count,
                                    rsp.payload_out, oldest_expected.payload_out));
      end
    end
  end

  // A hung block must not hang the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix(130, 0, 0);
    test_random_mix(130, 48, 0);
    test_random_mix(130, 0, 48);
    test_random_mix(130, 17, 17);
    test_fill_table();
    test_one_home();
    test_result_backpressure();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests and %0d results: %0d done, %0d full, %0d not found.",
             sent_count, checked_count, done_seen, full_seen, missing_seen);
    $display("Full at the entry limit %0d times, out of probes %0d times; input held %0d cycles.",
             full_by_count, full_by_probes, input_stall_cycles);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/qpht_pkg.sv
design/qpht_front.sv
design/qpht_cmd_queue.sv
design/qpht_back.sv
design/quadratic_probe_hash_table_unit.sv
tb/testbench.sv
